@@ rtl/core/dna_kmer_feature_extractor_unit_assert.svh @@
// Assertion macros used by the k-mer feature extractor checker.
`ifndef DNA_KMER_FEATURE_EXTRACTOR_UNIT_ASSERT_SVH
`define DNA_KMER_FEATURE_EXTRACTOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DKFE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("k-mer extractor check failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted.
`define DKFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("k-mer extractor check failed (next cycle)");

`endif

@@ rtl/core/dkfe_pkg.sv @@
// Package with types, constants and the entropy table of the k-mer feature extractor.
package dkfe_pkg;

    // Geometry of one k-mer and of the lane split.
    localparam int KMER_BASES = 21;
    localparam int BASE_W     = 2;
    localparam int KMER_W     = KMER_BASES * BASE_W;
    localparam int LANES      = 3;
    localparam int LANE_BASES = KMER_BASES / LANES;
    localparam int LANE_W     = LANE_BASES * BASE_W;
    localparam int LANE_CW    = $clog2(LANE_BASES + 1);
    localparam int COUNT_W    = 5;
    localparam int DIST_W     = 3;
    localparam int ENT_W      = 16;
    localparam int ESUM_W     = ENT_W + 2;
    localparam int NUM_SYMS   = 4;

    // Base codes.
    localparam logic [BASE_W-1:0] BASE_A = 2'd0;
    localparam logic [BASE_W-1:0] BASE_C = 2'd1;
    localparam logic [BASE_W-1:0] BASE_G = 2'd2;
    localparam logic [BASE_W-1:0] BASE_T = 2'd3;

    // What one lane reports about its slice of bases.
    typedef struct packed {
        logic [NUM_SYMS-1:0][LANE_CW-1:0] cnt;
        logic [BASE_W-1:0]                first;
        logic [BASE_W-1:0]                last;
        logic [LANE_CW-1:0]               head;
        logic [LANE_CW-1:0]               tail;
        logic [LANE_CW-1:0]               best;
        logic                             uniform;
    } t_lane_sum;

    // Merged features of a whole k-mer, before the entropy lookup.
    typedef struct packed {
        logic [NUM_SYMS-1:0][COUNT_W-1:0] cnt;
        logic [COUNT_W-1:0]               gc;
        logic [COUNT_W-1:0]               best;
        logic [DIST_W-1:0]                distinct;
    } t_merge;

    // Entropy term -(c/21)*log2(c/21) in unsigned Q0.16, rounded to nearest.
    function automatic logic [ENT_W-1:0] ent_q16(input logic [COUNT_W-1:0] c);
        logic [ENT_W-1:0] v;
        unique case (c)
            5'd0:    v = 16'd0;
            5'd1:    v = 16'd13707;
            5'd2:    v = 16'd21173;
            5'd3:    v = 16'd26283;
            5'd4:    v = 16'd29863;
            5'd5:    v = 16'd32306;
            5'd6:    v = 16'd33842;
            5'd7:    v = 16'd34624;
            5'd8:    v = 16'd34761;
            5'd9:    v = 16'd34333;
            5'd10:   v = 16'd33404;
            5'd11:   v = 16'd32024;
            5'd12:   v = 16'd30235;
            5'd13:   v = 16'd28069;
            5'd14:   v = 16'd25557;
            5'd15:   v = 16'd22724;
            5'd16:   v = 16'd19589;
            5'd17:   v = 16'd16173;
            5'd18:   v = 16'd12493;
            5'd19:   v = 16'd8562;
            5'd20:   v = 16'd4393;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/dna_kmer_feature_extractor_unit.sv @@
// A result item passes three register stages on its way to the output, the first
// one loaded at the edge that accepts its k-mer.
// Throughput: one item per cycle unless the output stalls; three lanes of seven bases each feed a
// merge stage, then an entropy lookup stage, each behind its own register.
// A waiting result does not block intake until all three stages are full.
// Reset (synchronous, active low) clears the stage valid flags only.
// Top level of the k-mer feature extractor: lanes, merge and entropy pipeline.
module dna_kmer_feature_extractor_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [dkfe_pkg::KMER_W-1:0]   i_kmer_code,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [dkfe_pkg::KMER_W-1:0]   o_kmer_echo,
    output logic [dkfe_pkg::COUNT_W-1:0]  o_count_a,
    output logic [dkfe_pkg::COUNT_W-1:0]  o_count_c,
    output logic [dkfe_pkg::COUNT_W-1:0]  o_count_g,
    output logic [dkfe_pkg::COUNT_W-1:0]  o_count_t,
    output logic [dkfe_pkg::COUNT_W-1:0]  o_gc_count,
    output logic [dkfe_pkg::COUNT_W-1:0]  o_longest_run,
    output logic [dkfe_pkg::DIST_W-1:0]   o_distinct_bases,
    output logic [dkfe_pkg::ENT_W-1:0]    o_entropy_half
);

    dkfe_pkg::t_lane_sum [dkfe_pkg::LANES-1:0] w_lanes;
    dkfe_pkg::t_lane_sum [dkfe_pkg::LANES-1:0] r_s1_lanes;
    dkfe_pkg::t_merge                          w_merge;
    dkfe_pkg::t_merge                          r_s2_merge;
    logic [dkfe_pkg::KMER_W-1:0]               r_s1_code;
    logic [dkfe_pkg::KMER_W-1:0]               r_s2_code;
    logic                                      r_s1_vld;
    logic                                      r_s2_vld;
    logic                                      r_s3_vld;
    logic                                      n_s1_vld;
    logic                                      n_s2_vld;
    logic                                      n_s3_vld;
    logic                                      w_rdy1;
    logic                                      w_rdy2;
    logic                                      w_rdy3;
    logic                                      w_in_acc;
    logic [dkfe_pkg::ESUM_W-1:0]               w_esum;
    logic [dkfe_pkg::ESUM_W-2:0]               w_ehalf;
    logic [dkfe_pkg::ENT_W-1:0]                w_ent;

    // Lanes work side by side on consecutive slices of the k-mer.
    for (genvar l = 0; l < dkfe_pkg::LANES; l++) begin : g_lane
        dkfe_lane u_lane (
            .i_bases (i_kmer_code[dkfe_pkg::KMER_W-1-l*dkfe_pkg::LANE_W -: dkfe_pkg::LANE_W]),
            .o_sum   (w_lanes[l])
        );
    end

    dkfe_merge u_merge (
        .i_lanes (r_s1_lanes),
        .o_merge (w_merge)
    );

    // A stage may load when it is empty or its contents move on this cycle.
    assign w_rdy3   = !r_s3_vld || !i_stall;
    assign w_rdy2   = !r_s2_vld || w_rdy3;
    assign w_rdy1   = !r_s1_vld || w_rdy2;
    assign o_stall  = !w_rdy1;
    assign w_in_acc = i_valid && w_rdy1;

    assign n_s1_vld = w_rdy1 ? i_valid  : r_s1_vld;
    assign n_s2_vld = w_rdy2 ? r_s1_vld : r_s2_vld;
    assign n_s3_vld = w_rdy3 ? r_s2_vld : r_s3_vld;

    // Entropy: four table terms, summed, halved and saturated.
    always_comb begin
        w_esum = dkfe_pkg::ESUM_W'(dkfe_pkg::ent_q16(r_s2_merge.cnt[dkfe_pkg::BASE_A]))
               + dkfe_pkg::ESUM_W'(dkfe_pkg::ent_q16(r_s2_merge.cnt[dkfe_pkg::BASE_C]))
               + dkfe_pkg::ESUM_W'(dkfe_pkg::ent_q16(r_s2_merge.cnt[dkfe_pkg::BASE_G]))
               + dkfe_pkg::ESUM_W'(dkfe_pkg::ent_q16(r_s2_merge.cnt[dkfe_pkg::BASE_T]));
        w_ehalf = w_esum[dkfe_pkg::ESUM_W-1:1];
        if (w_ehalf[dkfe_pkg::ESUM_W-2]) begin
            w_ent = '1;
        end else begin
            w_ent = w_ehalf[dkfe_pkg::ENT_W-1:0];
        end
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
            r_s2_vld <= n_s2_vld;
            r_s3_vld <= n_s3_vld;
        end
    end

    // Stage payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_lanes <= w_lanes;
            r_s1_code  <= i_kmer_code;
        end
        if (w_rdy2 && r_s1_vld) begin
            r_s2_merge <= w_merge;
            r_s2_code  <= r_s1_code;
        end
        if (w_rdy3 && r_s2_vld) begin
            o_kmer_echo      <= r_s2_code;
            o_count_a        <= r_s2_merge.cnt[dkfe_pkg::BASE_A];
            o_count_c        <= r_s2_merge.cnt[dkfe_pkg::BASE_C];
            o_count_g        <= r_s2_merge.cnt[dkfe_pkg::BASE_G];
            o_count_t        <= r_s2_merge.cnt[dkfe_pkg::BASE_T];
            o_gc_count       <= r_s2_merge.gc;
            o_longest_run    <= r_s2_merge.best;
            o_distinct_bases <= r_s2_merge.distinct;
            o_entropy_half   <= w_ent;
        end
    end

    assign o_valid = r_s3_vld;

endmodule

@@ rtl/core/dkfe_lane.sv @@
// One lane: base counts and run statistics over a seven-base slice of the k-mer.
module dkfe_lane (
    input  logic [dkfe_pkg::LANE_W-1:0] i_bases,
    output dkfe_pkg::t_lane_sum         o_sum
);

    // Walk the slice from its first base, tracking counts and runs.
    always_comb begin
        logic [dkfe_pkg::BASE_W-1:0]  b;
        logic [dkfe_pkg::BASE_W-1:0]  prev;
        logic [dkfe_pkg::LANE_CW-1:0] run;
        logic [dkfe_pkg::LANE_CW-1:0] best;
        logic [dkfe_pkg::LANE_CW-1:0] head;
        logic                         head_open;

        o_sum     = '0;
        prev      = i_bases[dkfe_pkg::LANE_W-1 -: dkfe_pkg::BASE_W];
        run       = dkfe_pkg::LANE_CW'(1);
        best      = dkfe_pkg::LANE_CW'(1);
        head      = dkfe_pkg::LANE_CW'(1);
        head_open = 1'b1;
        o_sum.cnt[prev] = dkfe_pkg::LANE_CW'(1);

        for (int i = 1; i < dkfe_pkg::LANE_BASES; i++) begin
            b = i_bases[dkfe_pkg::LANE_W-1-i*dkfe_pkg::BASE_W -: dkfe_pkg::BASE_W];
            o_sum.cnt[b] = o_sum.cnt[b] + dkfe_pkg::LANE_CW'(1);
            if (b == prev) begin
                run = run + dkfe_pkg::LANE_CW'(1);
            end else begin
                run = dkfe_pkg::LANE_CW'(1);
            end
            if (run > best) begin
                best = run;
            end
            if (head_open && (b == prev)) begin
                head = head + dkfe_pkg::LANE_CW'(1);
            end else begin
                head_open = 1'b0;
            end
            prev = b;
        end

        o_sum.first   = i_bases[dkfe_pkg::LANE_W-1 -: dkfe_pkg::BASE_W];
        o_sum.last    = prev;
        o_sum.head    = head;
        o_sum.tail    = run;
        o_sum.best    = best;
        o_sum.uniform = head_open;
    end

endmodule

@@ rtl/core/dkfe_merge.sv @@
// Merge stage: joins the lane results into counts, GC count, longest run and distinct bases.
module dkfe_merge (
    input  dkfe_pkg::t_lane_sum [dkfe_pkg::LANES-1:0] i_lanes,
    output dkfe_pkg::t_merge                          o_merge
);

    // Combine lanes in base order; a run may cross lane boundaries.
    always_comb begin
        logic [dkfe_pkg::COUNT_W-1:0] best;
        logic [dkfe_pkg::COUNT_W-1:0] tail;
        logic [dkfe_pkg::COUNT_W-1:0] joined;
        logic [dkfe_pkg::DIST_W-1:0]  present;

        o_merge = '0;
        best    = dkfe_pkg::COUNT_W'(i_lanes[0].best);
        tail    = dkfe_pkg::COUNT_W'(i_lanes[0].tail);
        joined  = '0;
        present = '0;

        for (int l = 1; l < dkfe_pkg::LANES; l++) begin
            if (i_lanes[l].first == i_lanes[l-1].last) begin
                joined = tail + dkfe_pkg::COUNT_W'(i_lanes[l].head);
                if (joined > best) begin
                    best = joined;
                end
                if (i_lanes[l].uniform) begin
                    tail = joined;
                end else begin
                    tail = dkfe_pkg::COUNT_W'(i_lanes[l].tail);
                end
            end else begin
                tail = dkfe_pkg::COUNT_W'(i_lanes[l].tail);
            end
            if (dkfe_pkg::COUNT_W'(i_lanes[l].best) > best) begin
                best = dkfe_pkg::COUNT_W'(i_lanes[l].best);
            end
        end

        // Per-base totals and the number of bases that occur.
        for (int s = 0; s < dkfe_pkg::NUM_SYMS; s++) begin
            for (int l = 0; l < dkfe_pkg::LANES; l++) begin
                o_merge.cnt[s] = o_merge.cnt[s] + dkfe_pkg::COUNT_W'(i_lanes[l].cnt[s]);
            end
            if (o_merge.cnt[s] != '0) begin
                present = present + dkfe_pkg::DIST_W'(1);
            end
        end

        o_merge.gc       = o_merge.cnt[dkfe_pkg::BASE_C] + o_merge.cnt[dkfe_pkg::BASE_G];
        o_merge.best     = best;
        o_merge.distinct = present;
    end

endmodule

@@ rtl/core/dkfe_checker.sv @@
// Port-level checker for the k-mer feature extractor, bound to the top level.
`include "dna_kmer_feature_extractor_unit_assert.svh"

module dkfe_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [dkfe_pkg::KMER_W-1:0]   o_kmer_echo,
    input logic [dkfe_pkg::COUNT_W-1:0]  o_count_a,
    input logic [dkfe_pkg::COUNT_W-1:0]  o_count_c,
    input logic [dkfe_pkg::COUNT_W-1:0]  o_count_g,
    input logic [dkfe_pkg::COUNT_W-1:0]  o_count_t,
    input logic [dkfe_pkg::COUNT_W-1:0]  o_gc_count,
    input logic [dkfe_pkg::COUNT_W-1:0]  o_longest_run,
    input logic [dkfe_pkg::DIST_W-1:0]   o_distinct_bases
);

    // A stalled result item stays on the port unchanged.
    `DKFE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_kmer_echo))

    // The four base counts always cover the whole k-mer.
    `DKFE_ASSERT_NOW(a_count_sum, i_clk, i_rst_n, o_valid, 7'(o_count_a) + 7'(o_count_c) + 7'(o_count_g) + 7'(o_count_t) == 7'd21)

    // The GC count agrees with the C and G counts.
    `DKFE_ASSERT_NOW(a_gc_match, i_clk, i_rst_n, o_valid, 6'(o_gc_count) == 6'(o_count_c) + 6'(o_count_g))

    // A single distinct base means one run over all bases.
    `DKFE_ASSERT_NOW(a_uniform_run, i_clk, i_rst_n, o_valid && (o_distinct_bases == 3'd1), o_longest_run == 5'd21)

endmodule

bind dna_kmer_feature_extractor_unit dkfe_checker u_dkfe_checker (.*);
